FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects a signal named clk in the enclosing scope; CHK_ASSERT also needs rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/brs_pkg.sv
// Shared types, constants and helpers of the Bratu stencil residual block.
// No dependencies; used by the front, queue, back end and top level.
package brs_pkg;

  localparam int MAX_SIDE_DEF = 32;
  localparam int POS_W        = 8;   // row/column counter width, covers sides up to 256
  localparam int SIDE_W       = 9;   // grid side width, holds 256
  localparam int QUEUE_DEPTH  = 4;   // power of two
  localparam int APB_AW       = 4;
  localparam int OUT_W        = 80;

  localparam logic [1:0] REG_GRID_SIZE    = 2'd0;
  localparam logic [1:0] REG_EAST_COEF    = 2'd1;
  localparam logic [1:0] REG_WEST_COEF    = 2'd2;
  localparam logic [1:0] REG_SOURCE_SCALE = 2'd3;

  localparam logic [5:0]         GRID_SIZE_RST = 6'd32;
  localparam logic signed [31:0] COEF_RST      = -32'sd65536;

  localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
  localparam logic [32:0] LN2_Q30   = 33'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [3:0]  EXP_TERMS = 4'd10;

  typedef struct packed {
    logic signed [31:0] value;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [1:0]         slot;      // row index mod 3
    logic               grid_end;
    logic [SIDE_W-1:0]  side;
  } rec_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

FILE: src/brs_fifo.sv
// Short record queue between the front end and the back end.
// Depends on brs_pkg (rec_t, QUEUE_DEPTH).
module brs_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brs_pkg::rec_t wr_rec,
  output logic          full,
  input  logic          pop,
  output brs_pkg::rec_t rd_rec,
  output logic          empty
);

  localparam int PW = $clog2(brs_pkg::QUEUE_DEPTH);

  brs_pkg::rec_t  entries [brs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full   = (count == (PW+1)'(brs_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

FILE: src/brs_front.sv
// Front end: accepts grid beats, tracks row/column and classifies row and grid ends.
// Depends on brs_pkg (rec_t, slot_inc).
module brs_front #(
  parameter int MAX_SIDE = brs_pkg::MAX_SIDE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,
  input  logic [5:0]    grid_size,
  output logic          push,
  output brs_pkg::rec_t rec,
  input  logic          q_full
);

  logic [brs_pkg::POS_W-1:0]  in_row;
  logic [brs_pkg::POS_W-1:0]  in_col;
  logic [1:0]                 in_slot;
  logic [brs_pkg::SIDE_W-1:0] side;
  logic                       row_end;
  logic                       grid_end;

  // Clamp the side: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (grid_size == 6'd0) begin
      side = brs_pkg::SIDE_W'(1);
    end else if (int'(grid_size) > MAX_SIDE) begin
      side = brs_pkg::SIDE_W'(MAX_SIDE);
    end else begin
      side = brs_pkg::SIDE_W'(grid_size);
    end
  end

  assign row_end  = (brs_pkg::SIDE_W'(in_col) + brs_pkg::SIDE_W'(1)) >= side;
  assign grid_end = row_end && ((brs_pkg::SIDE_W'(in_row) + brs_pkg::SIDE_W'(1)) >= side);

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  always_comb begin
    rec.value    = $signed(s_axis_tdata);
    rec.row      = in_row;
    rec.col      = in_col;
    rec.slot     = in_slot;
    rec.grid_end = grid_end;
    rec.side     = side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      in_slot <= 2'd0;
    end else if (push) begin
      if (grid_end) begin
        in_row  <= '0;
        in_col  <= '0;
        in_slot <= 2'd0;
      end else if (row_end) begin
        in_col  <= '0;
        in_row  <= in_row + 1'b1;
        in_slot <= brs_pkg::slot_inc(in_slot);
      end else begin
        in_col <= in_col + 1'b1;
      end
    end
  end

endmodule

FILE: src/brs_sqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
// No package dependencies.
module brs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  step;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign done   = !busy;
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= value;
      rem  <= '0;
      root <= '0;
      step <= 5'd31;
    end else if (busy) begin
      if (rem_sh >= trial) begin
        rem  <= 34'(rem_sh - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= 34'(rem_sh);
        root <= {root[30:0], 1'b0};
      end
      rad  <= {rad[61:0], 2'b00};
      step <= step - 5'd1;
    end
  end

endmodule

FILE: src/brs_back.sv
// Back end: holds three grid rows in a memory and works out each residual
// on one shared multiplier; accumulates squares and takes the norm at grid end.
// Depends on brs_pkg and brs_sqrt.
module brs_back #(
  parameter int MAX_SIDE = brs_pkg::MAX_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  brs_pkg::rec_t             q_head,
  input  logic signed [31:0]        east_coef,
  input  logic signed [31:0]        west_coef,
  input  logic signed [31:0]        source_scale,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [brs_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);

  localparam int DEPTH = 3 * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = brs_pkg::POS_W;
  localparam int SW    = brs_pkg::SIDE_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WRITE = 5'd1;
  localparam logic [4:0] S_RD0   = 5'd2;
  localparam logic [4:0] S_RD1   = 5'd3;
  localparam logic [4:0] S_RD2   = 5'd4;
  localparam logic [4:0] S_KF    = 5'd5;
  localparam logic [4:0] S_Y     = 5'd6;
  localparam logic [4:0] S_PA    = 5'd7;
  localparam logic [4:0] S_PB    = 5'd8;
  localparam logic [4:0] S_PC    = 5'd9;
  localparam logic [4:0] S_ME    = 5'd10;
  localparam logic [4:0] S_MW    = 5'd11;
  localparam logic [4:0] S_MS    = 5'd12;
  localparam logic [4:0] S_SUM   = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_ACC   = 5'd15;
  localparam logic [4:0] S_SQRT  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] s, input logic [PW-1:0] c);
    return AW'(int'(s) * MAX_SIDE + int'(c));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v[65:31] == '0 || v[65:31] == '1) return v[31:0];
    else if (v[65]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = (v + 66'sd32768) >>> 16;
    return sat32(s);
  endfunction

  // floor((2^32-1)/j); the quotient comes out at most one short.
  function automatic logic [31:0] recip(input logic [3:0] j);
    case (j)
      4'd1:    return 32'd4294967295;
      4'd2:    return 32'd2147483647;
      4'd3:    return 32'd1431655765;
      4'd4:    return 32'd1073741823;
      4'd5:    return 32'd858993459;
      4'd6:    return 32'd715827882;
      4'd7:    return 32'd613566756;
      4'd8:    return 32'd536870911;
      4'd9:    return 32'd477218588;
      4'd10:   return 32'd429496729;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [30:0] exp_scale(input logic [30:0] pv,
                                            input logic signed [19:0] kv);
    logic signed [20:0] sh;
    sh = 21'sd14 - 21'(kv);
    if (kv >= 20'sd15) return 31'h7FFF_FFFF;
    else if (kv == 20'sd14) return pv;
    else if (sh >= 21'sd31) return '0;
    else return pv >> sh[4:0];
  endfunction

  logic [4:0]          state;
  brs_pkg::rec_t       cur;

  logic                tloop;
  logic [PW-1:0]       trow;
  logic [PW-1:0]       tcol;
  logic [1:0]          tslot;
  logic [1:0]          tnslot;
  logic                thasn;
  logic signed [31:0]  tsouth;
  logic                tlast;

  logic signed [31:0]  mem [DEPTH];
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  logic signed [31:0]  rd_a;
  logic signed [31:0]  rd_b;

  logic signed [31:0]  vx, vn, vw, ve;
  logic signed [19:0]  k;
  logic [29:0]         y;
  logic [30:0]         p;
  logic [30:0]         q;
  logic [3:0]          j;
  logic [30:0]         ev;
  logic signed [31:0]  qe, qw;
  logic signed [31:0]  res;
  logic [63:0]         square_sum;

  logic signed [32:0]  ma, mb;
  logic signed [65:0]  prod;

  logic                has_east;
  logic [PW-1:0]       west_col;
  logic [PW-1:0]       east_col;
  logic signed [31:0]  qm;
  logic signed [37:0]  sum38;
  logic [31:0]         mag;
  logic [64:0]         acc_sum;
  logic [63:0]         square_sum_next;
  logic [30:0]         qa;
  logic [30:0]         qa_fix;
  logic [34:0]         qrem;
  logic                out_free;
  logic                out_load;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [31:0]         sqrt_root;

  assign has_east = (SW'(tcol) + SW'(1)) < cur.side;
  assign west_col = (tcol != '0) ? tcol - 1'b1 : tcol;
  assign east_col = has_east ? tcol + 1'b1 : tcol;
  assign qm       = qmul(prod);
  assign sum38    = (38'(vx) <<< 2) - 38'(vn) - 38'(tsouth) + 38'(qe) + 38'(qw) - 38'(qm);
  assign mag      = res[31] ? (~res + 32'd1) : res;
  assign acc_sum  = {1'b0, square_sum} + {1'b0, prod[63:0]};
  assign square_sum_next = acc_sum[64] ? '1 : acc_sum[63:0];
  assign qa       = prod[62:32];
  assign qrem     = 35'(q) - 35'(qa) * 35'(j);
  assign qa_fix   = (qrem >= 35'(j)) ? qa + 31'd1 : qa;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == S_OUT) && out_free;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign sqrt_start = (state == S_ACC) && tlast;

  brs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (square_sum_next),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    rd_addr_a = slot_addr(tslot, tcol);
    rd_addr_b = slot_addr(tnslot, tcol);
    if (state == S_RD1) begin
      rd_addr_a = slot_addr(tslot, west_col);
      rd_addr_b = slot_addr(tslot, east_col);
    end
  end

  // Operand select of the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_RD2: begin
        ma = {vx[31], vx};
        mb = brs_pkg::LOG2E_Q30;
      end
      S_KF: begin
        ma = {3'b000, prod[45:16]};
        mb = brs_pkg::LN2_Q30;
      end
      S_PA: begin
        ma = {3'b000, y};
        mb = {2'b00, p};
      end
      S_PB: begin
        ma = {2'b00, prod[60:30]};
        mb = {1'b0, recip(j)};
      end
      S_ME: begin
        ma = {east_coef[31], east_coef};
        mb = {ve[31], ve};
      end
      S_MW: begin
        ma = {west_coef[31], west_coef};
        mb = {vw[31], vw};
      end
      S_MS: begin
        ma = {source_scale[31], source_scale};
        mb = {2'b00, ev};
      end
      S_SQ: begin
        ma = {1'b0, mag};
        mb = {1'b0, mag};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[slot_addr(cur.slot, cur.col)] <= cur.value;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      square_sum    <= '0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (cur.row != '0) begin
            tloop  <= 1'b0;
            trow   <= cur.row - 1'b1;
            tcol   <= cur.col;
            tslot  <= brs_pkg::slot_dec(cur.slot);
            tnslot <= brs_pkg::slot_inc(cur.slot);
            thasn  <= (cur.row != PW'(1));
            tsouth <= cur.value;
            tlast  <= 1'b0;
            state  <= S_RD0;
          end else if (cur.grid_end) begin
            tloop  <= 1'b1;
            trow   <= cur.row;
            tcol   <= '0;
            tslot  <= cur.slot;
            tnslot <= brs_pkg::slot_dec(cur.slot);
            thasn  <= 1'b0;
            tsouth <= '0;
            tlast  <= (cur.side == SW'(1));
            state  <= S_RD0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          vx    <= rd_a;
          vn    <= thasn ? rd_b : '0;
          state <= S_RD2;
        end
        S_RD2: begin
          vw    <= (tcol != '0) ? rd_a : '0;
          ve    <= has_east ? rd_b : '0;
          state <= S_KF;
        end
        S_KF: begin
          k     <= prod[65:46];
          state <= S_Y;
        end
        S_Y: begin
          y     <= prod[59:30];
          p     <= brs_pkg::ONE_Q30;
          j     <= brs_pkg::EXP_TERMS;
          state <= S_PA;
        end
        S_PA: state <= S_PB;
        S_PB: begin
          q     <= prod[60:30];
          state <= S_PC;
        end
        S_PC: begin
          p <= brs_pkg::ONE_Q30 + qa_fix;
          if (j == 4'd1) begin
            state <= S_ME;
          end else begin
            j     <= j - 4'd1;
            state <= S_PA;
          end
        end
        S_ME: begin
          ev    <= exp_scale(p, k);
          state <= S_MW;
        end
        S_MW: begin
          qe    <= qm;
          state <= S_MS;
        end
        S_MS: begin
          qw    <= qm;
          state <= S_SUM;
        end
        S_SUM: begin
          res   <= sat32(66'(sum38));
          state <= S_SQ;
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          square_sum <= square_sum_next;
          state      <= tlast ? S_SQRT : S_OUT;
        end
        S_SQRT: begin
          if (sqrt_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tlast  <= tlast;
            m_axis_tdata  <= {6'b0, (tlast ? sqrt_root : 32'd0), 5'(tcol), 5'(trow), res};
            if (!tloop && cur.grid_end) begin
              // previous-row beat done; flush the final row
              tloop  <= 1'b1;
              trow   <= cur.row;
              tcol   <= '0;
              tslot  <= cur.slot;
              tnslot <= brs_pkg::slot_dec(cur.slot);
              thasn  <= (cur.row != '0);
              tsouth <= '0;
              tlast  <= (cur.side == SW'(1));
              state  <= S_RD0;
            end else if (tloop && !tlast) begin
              tcol  <= tcol + 1'b1;
              tlast <= ((SW'(tcol) + SW'(2)) == cur.side);
              state <= S_RD0;
            end else begin
              if (cur.grid_end) square_sum <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/bratu_stencil_residual.sv
// Top level of the streamed five-point Bratu residual with its register port.
// Depends on brs_pkg, brs_front, brs_fifo and brs_back.
//
//   channel     signals                         direction  content
//   s_axis      tvalid tready tdata[31:0]       in         grid_value
//   m_axis      tvalid tready tdata[79:0] tlast out        residual, row, col, norm; last
//   apb         psel penable pwrite paddr ...   in/out     grid_size, east/west coef, scale
//
// Each residual is worked out on the one shared multiplier, including the ten-term
// exp series; the last residual of a grid also takes a square root.
// Each beat is popped and stored, then produces no residual in row 0, one
// otherwise, plus the whole final row on the grid's final beat.
// Reset is synchronous; the row memory needs no clearing pass.
// The four-entry queue keeps taking input beats until full while the back end stalls on output.
module bratu_stencil_residual #(
  parameter int MAX_SIDE = brs_pkg::MAX_SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] grid_value
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [brs_pkg::OUT_W-1:0]  m_axis_tdata,   // [31:0] residual, [36:32] point_row,
                                                     // [41:37] point_col, [73:42] norm
  output logic                       m_axis_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [5:0]         grid_size;
  logic signed [31:0] east_coef;
  logic signed [31:0] west_coef;
  logic signed [31:0] source_scale;
  logic               cfg_wr;

  logic               push;
  brs_pkg::rec_t      wr_rec;
  logic               q_full;
  logic               q_pop;
  brs_pkg::rec_t      q_head;
  logic               q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size    <= brs_pkg::GRID_SIZE_RST;
      east_coef    <= brs_pkg::COEF_RST;
      west_coef    <= brs_pkg::COEF_RST;
      source_scale <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        brs_pkg::REG_GRID_SIZE:    grid_size    <= pwdata[5:0];
        brs_pkg::REG_EAST_COEF:    east_coef    <= pwdata;
        brs_pkg::REG_WEST_COEF:    west_coef    <= pwdata;
        brs_pkg::REG_SOURCE_SCALE: source_scale <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      brs_pkg::REG_GRID_SIZE:    prdata = {26'b0, grid_size};
      brs_pkg::REG_EAST_COEF:    prdata = east_coef;
      brs_pkg::REG_WEST_COEF:    prdata = west_coef;
      brs_pkg::REG_SOURCE_SCALE: prdata = source_scale;
      default:                   prdata = '0;
    endcase
  end

  brs_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .grid_size     (grid_size),
    .push          (push),
    .rec           (wr_rec),
    .q_full        (q_full)
  );

  brs_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_head),
    .empty  (q_empty)
  );

  brs_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_head        (q_head),
    .east_coef     (east_coef),
    .west_coef     (west_coef),
    .source_scale  (source_scale),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: src/brs_checker.sv
// Port-level checks of the Bratu stencil residual block, bound to the top level.
// Depends on assert_macros.svh and brs_pkg.
`include "assert_macros.svh"

module brs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [brs_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tlast
);

  `CHK_ASSERT(a_norm_only_last, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[73:42] == 32'd0), "norm nonzero on a beat that is not last")
  `CHK_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output beat changed")
  `CHK_ASSERT_ALWAYS(a_rst_out_idle, $past(rst) |-> !m_axis_tvalid, "output valid right after reset")
  `CHK_ASSERT_ALWAYS(a_rst_in_ready, $past(rst) |-> s_axis_tready, "input not ready right after reset")

endmodule

bind bratu_stencil_residual brs_checker u_checker (.*);
